/* hw/rtl/cdc_pkg.sv */
// Shared types, constants and calendar functions for the calendar date counter.
package cdc_pkg;

  localparam int YEAR_W     = 16;
  localparam int M400_W     = 9;
  localparam int STEPCNT_W  = 17;

  // floor(y / 400) == (y * RECIP_400) >> RECIP_SHIFT for every YEAR_W-bit year
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_W     = 17;
  localparam int QUOT_W      = 8;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_400 = RECIP_W'(83887);

  localparam logic [YEAR_W-1:0] YEAR_MAX   = {YEAR_W{1'b1}};
  localparam logic [YEAR_W-1:0] YEAR_RESET = YEAR_W'(2000);
  localparam logic [M400_W-1:0] M400_RESET = M400_W'(2000 % 400);
  localparam logic [M400_W-1:0] M400_LAST  = M400_W'(399);
  localparam logic [M400_W:0]   M400_DIV   = (M400_W + 1)'(400);

  // Input opcodes
  localparam logic [1:0] OP_SET_MONTH = 2'd0;
  localparam logic [1:0] OP_SET_DAY   = 2'd1;
  localparam logic [1:0] OP_SET_YEAR  = 2'd2;
  localparam logic [1:0] OP_ADD_DAYS  = 2'd3;

  // Date unit commands
  localparam logic [2:0] DC_NOP      = 3'd0;
  localparam logic [2:0] DC_LD_MONTH = 3'd1;
  localparam logic [2:0] DC_SET_DAY  = 3'd2;
  localparam logic [2:0] DC_LD_YEAR  = 3'd3;
  localparam logic [2:0] DC_CLAMP    = 3'd4;
  localparam logic [2:0] DC_STEP_FWD = 3'd5;
  localparam logic [2:0] DC_STEP_BWD = 3'd6;

  typedef struct packed {
    logic [2:0]        op;
    logic [3:0]        month;
    logic [5:0]        day;
    logic [YEAR_W-1:0] year;
    logic [M400_W-1:0] m400;
  } cdc_cmd_t;

  typedef struct packed {
    logic [3:0]        month;
    logic [4:0]        day;
    logic [YEAR_W-1:0] year;
    logic              at_max;
    logic              at_min;
  } cdc_stat_t;

  typedef logic [4:0] mlen_tab_t [12];
  localparam mlen_tab_t MONTH_LEN = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  // Leap year from the year modulo 400
  function automatic logic leap_m400(input logic [M400_W-1:0] m);
    return (m[1:0] == 2'b00) && (m != M400_W'(100)) && (m != M400_W'(200)) &&
           (m != M400_W'(300));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    idx = ((m < 4'd1) || (m > 4'd12)) ? 4'd11 : (m - 4'd1);
    return MONTH_LEN[idx] + {4'd0, (m == 4'd2) && leap};
  endfunction

endpackage

/* hw/rtl/calendar_date_up_down_counter.sv */
// Top level of the Gregorian calendar date counter: handshake, sequencer and result register.
//
// Holds one date (month/day/year, reset 1/1/2000) and returns the stored date for every
// input word. Set day runs S_EXEC and S_DONE, set month S_EXEC, S_CLAMP and S_DONE; set year
// starts the modulo-400 unit that derives the leap-year phase by reciprocal multiplication,
// waits in S_REM for its result, then loads the year and clamps the day; add days walks the
// date one day per clock through the shared step unit. A step that would leave year 0 or the
// maximum year stops the walk and raises range_limit. The next input word is taken as soon
// as the sequencer is idle, even while the previous result waits on out_tready.
module calendar_date_up_down_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // month_value[3:0], day_value[9:4], year_value[25:10],
                                  // day_count[41:26], zero[47:42]
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // cur_month[3:0], cur_day[8:4], cur_year[24:9],
                                  // range_limit[25], zero[31:26]
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_REM   = 3'd2;
  localparam logic [2:0] S_CLAMP = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [1:0]                    op_r, op_nxt;
  logic [3:0]                    mv_r, mv_nxt;
  logic [5:0]                    dv_r, dv_nxt;
  logic [cdc_pkg::YEAR_W-1:0]    yv_r, yv_nxt;
  logic                          neg_r, neg_nxt;
  logic [cdc_pkg::STEPCNT_W-1:0] cnt_r, cnt_nxt;
  logic                          limit_r, limit_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [25:0]                   out_data_r, out_data_nxt;

  logic                          accept;
  logic [cdc_pkg::STEPCNT_W-1:0] cnt_ext;
  logic                          rem_start;
  logic                          rem_done;
  logic [cdc_pkg::M400_W-1:0]    rem_val;
  cdc_pkg::cdc_cmd_t             cmd;
  cdc_pkg::cdc_stat_t            stat;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cnt_ext   = {in_tdata[41], in_tdata[41:26]};

  cdc_rem400 u_rem400 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .value (yv_r),
    .done  (rem_done),
    .rem   (rem_val)
  );

  cdc_date_unit u_date (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    mv_nxt        = mv_r;
    dv_nxt        = dv_r;
    yv_nxt        = yv_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    limit_nxt     = limit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rem_start     = 1'b0;
    cmd           = '0;
    cmd.op        = cdc_pkg::DC_NOP;
    cmd.month     = mv_r;
    cmd.day       = dv_r;
    cmd.year      = yv_r;
    cmd.m400      = rem_val;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_tuser;
          mv_nxt    = in_tdata[3:0];
          dv_nxt    = in_tdata[9:4];
          yv_nxt    = in_tdata[25:10];
          neg_nxt   = in_tdata[41];
          cnt_nxt   = in_tdata[41] ? (cdc_pkg::STEPCNT_W'(0) - cnt_ext) : cnt_ext;
          limit_nxt = 1'b0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          cdc_pkg::OP_SET_MONTH: begin
            cmd.op = cdc_pkg::DC_LD_MONTH;
            if (mv_r < 4'd1)       cmd.month = 4'd1;
            else if (mv_r > 4'd12) cmd.month = 4'd12;
            state_nxt = S_CLAMP;
          end
          cdc_pkg::OP_SET_DAY: begin
            cmd.op    = cdc_pkg::DC_SET_DAY;
            state_nxt = S_DONE;
          end
          cdc_pkg::OP_SET_YEAR: begin
            rem_start = 1'b1;
            state_nxt = S_REM;
          end
          cdc_pkg::OP_ADD_DAYS: state_nxt = S_STEP;
          default: state_nxt = S_DONE;
        endcase
      end
      S_REM: begin
        if (rem_done) begin
          cmd.op    = cdc_pkg::DC_LD_YEAR;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.op    = cdc_pkg::DC_CLAMP;
        state_nxt = S_DONE;
      end
      S_STEP: begin
        priority if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else if (neg_r ? stat.at_min : stat.at_max) begin
          limit_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.op  = neg_r ? cdc_pkg::DC_STEP_BWD : cdc_pkg::DC_STEP_FWD;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {limit_r, stat.year[15:0], stat.day, stat.month};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    mv_r       <= mv_nxt;
    dv_r       <= dv_nxt;
    yv_r       <= yv_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    limit_r    <= limit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

endmodule

/* hw/rtl/cdc_rem400.sv */
// Remainder of a year modulo 400 by reciprocal multiplication: the quotient is registered first, then the remainder.
module cdc_rem400 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cdc_pkg::YEAR_W-1:0]    value,
  output logic                          done,
  output logic [cdc_pkg::M400_W-1:0]    rem
);

  logic                         mul_vld_r, mul_vld_nxt;
  logic                         done_r, done_nxt;
  logic [cdc_pkg::YEAR_W-1:0]   val_r, val_nxt;
  logic [cdc_pkg::QUOT_W-1:0]   quot_r, quot_nxt;
  logic [cdc_pkg::M400_W-1:0]   rem_r, rem_nxt;
  logic [cdc_pkg::PROD_W-1:0]   prod;
  logic [cdc_pkg::YEAR_W-1:0]   back;

  // quotient first, then the remainder from it
  assign prod = cdc_pkg::PROD_W'(value) * cdc_pkg::PROD_W'(cdc_pkg::RECIP_400);
  assign back = cdc_pkg::YEAR_W'(quot_r) * cdc_pkg::YEAR_W'(cdc_pkg::M400_DIV);

  always_comb begin
    mul_vld_nxt = start;
    done_nxt    = mul_vld_r;
    val_nxt     = val_r;
    quot_nxt    = quot_r;
    rem_nxt     = rem_r;
    if (start) begin
      val_nxt  = value;
      quot_nxt = prod[cdc_pkg::RECIP_SHIFT +: cdc_pkg::QUOT_W];
    end
    if (mul_vld_r) rem_nxt = cdc_pkg::M400_W'(val_r - back);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      mul_vld_r <= mul_vld_nxt;
      done_r    <= done_nxt;
    end
    val_r  <= val_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hw/rtl/cdc_date_unit.sv */
// Date register and the shared update unit: loads, clamps and single-day steps.
module cdc_date_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  cdc_pkg::cdc_cmd_t  cmd,
  output cdc_pkg::cdc_stat_t stat
);

  logic [3:0]                 month_r, month_nxt;
  logic [4:0]                 day_r, day_nxt;
  logic [cdc_pkg::YEAR_W-1:0] year_r, year_nxt;
  logic [cdc_pkg::M400_W-1:0] m400_r, m400_nxt;
  logic                       leap;
  logic [4:0]                 len, prev_len;

  assign leap     = cdc_pkg::leap_m400(m400_r);
  assign len      = cdc_pkg::month_len(month_r, leap);
  assign prev_len = cdc_pkg::month_len(month_r - 4'd1, leap);

  always_comb begin
    month_nxt = month_r;
    day_nxt   = day_r;
    year_nxt  = year_r;
    m400_nxt  = m400_r;
    unique case (cmd.op)
      cdc_pkg::DC_LD_MONTH: month_nxt = cmd.month;
      cdc_pkg::DC_SET_DAY: begin
        if (cmd.day < 6'd1)              day_nxt = 5'd1;
        else if (cmd.day > {1'b0, len})  day_nxt = len;
        else                             day_nxt = cmd.day[4:0];
      end
      cdc_pkg::DC_LD_YEAR: begin
        year_nxt = cmd.year;
        m400_nxt = cmd.m400;
      end
      cdc_pkg::DC_CLAMP: begin
        if (day_r > len)        day_nxt = len;
        else if (day_r < 5'd1)  day_nxt = 5'd1;
      end
      cdc_pkg::DC_STEP_FWD: begin
        if (day_r < len) begin
          day_nxt = day_r + 5'd1;
        end else if (month_r < 4'd12) begin
          month_nxt = month_r + 4'd1;
          day_nxt   = 5'd1;
        end else if (year_r != cdc_pkg::YEAR_MAX) begin
          year_nxt  = year_r + 1'b1;
          month_nxt = 4'd1;
          day_nxt   = 5'd1;
          m400_nxt  = (m400_r == cdc_pkg::M400_LAST) ? '0 : m400_r + 1'b1;
        end
      end
      cdc_pkg::DC_STEP_BWD: begin
        if (day_r > 5'd1) begin
          day_nxt = day_r - 5'd1;
        end else if (month_r > 4'd1) begin
          month_nxt = month_r - 4'd1;
          day_nxt   = prev_len;
        end else if (year_r != '0) begin
          year_nxt  = year_r - 1'b1;
          month_nxt = 4'd12;
          day_nxt   = 5'd31;
          m400_nxt  = (m400_r == '0) ? cdc_pkg::M400_LAST : m400_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      month_r <= 4'd1;
      day_r   <= 5'd1;
      year_r  <= cdc_pkg::YEAR_RESET;
      m400_r  <= cdc_pkg::M400_RESET;
    end else begin
      month_r <= month_nxt;
      day_r   <= day_nxt;
      year_r  <= year_nxt;
      m400_r  <= m400_nxt;
    end
  end

  assign stat.month  = month_r;
  assign stat.day    = day_r;
  assign stat.year   = year_r;
  assign stat.at_max = (day_r >= len) && (month_r >= 4'd12) &&
                       (year_r == cdc_pkg::YEAR_MAX);
  assign stat.at_min = (day_r <= 5'd1) && (month_r <= 4'd1) && (year_r == '0);

endmodule
